/* rtl/core/fclp_pkg.sv */
`timescale 1ns / 1ps
// Package for the fence command line parser.
// Holds the result status codes, the character constants, the field widths and a digit test.
// It has no dependencies.
package fclp_pkg;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int NODE_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int MASK_W   = 5;
    localparam int COUNT_W  = 3;
    localparam int LINE_LEN = 4;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_SET    = 3'd0,
        STATUS_REPORT = 3'd1,
        STATUS_SHORT  = 3'd2,
        STATUS_LONG   = 3'd3,
        STATUS_FORMAT = 3'd4,
        STATUS_RANGE  = 3'd5,
        STATUS_STATE  = 3'd6
    } status_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

/* rtl/core/fence_command_line_parser.sv */
`timescale 1ns / 1ps
// Top level of the fence command line parser: splits a byte stream into lines,
// checks each line against the form "DD:D" and keeps the fence bit of each node.
// Depends on fclp_pkg.
//
// The byte that ends a line is taken into the input register; its result is then
// loaded into the result register when that byte advances.
// Throughput: one byte per cycle; a byte that yields a result waits while an earlier
// result has not yet been taken by the receiver.
// Reset clears the handshake state, the character count, the discard flag and
// all fence bits; the line buffer is not reset.
module fence_command_line_parser #(
    parameter int NODE_COUNT = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] node_id, [10:7] state_digit, [15:11] fenced_mask
    output logic [fclp_pkg::STATUS_W-1:0] m_tuser   // [2:0] status
);
    import fclp_pkg::*;

    localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(NODE_COUNT);

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                end_reg;

    logic [CHAR_W-1:0]   line_reg [LINE_LEN];
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                discard_reg, discard_next;
    logic [MASK_W-1:0]   fence_reg, fence_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic [MASK_W-1:0]   mask_reg;

    logic                term;
    logic                produce;
    logic                buf_write;
    logic                advance;
    logic                format_ok;
    logic [NODE_W-1:0]   node_val;
    logic [DIGIT_W-1:0]  digit_val;
    logic [DIGIT_W-1:0]  tens;

    assign term      = end_reg || (char_reg == CHAR_LF) || (char_reg == CHAR_CR);
    assign format_ok = (line_reg[2] == CHAR_COLON) && is_digit(line_reg[0])
                       && is_digit(line_reg[1]) && is_digit(line_reg[3]);
    assign tens      = line_reg[0][DIGIT_W-1:0];
    assign node_val  = {tens, 3'b000} + {2'b00, tens, 1'b0}
                       + {3'b000, line_reg[1][DIGIT_W-1:0]};
    assign digit_val = line_reg[3][DIGIT_W-1:0];

    always_comb
    begin
        produce      = 1'b0;
        buf_write    = 1'b0;
        count_next   = count_reg;
        discard_next = discard_reg;
        fence_next   = fence_reg;
        status_next  = STATUS_SHORT;
        node_next    = '0;
        digit_next   = '0;
        if (discard_reg)
        begin
            if (term)
            begin
                discard_next = 1'b0;
            end
        end
        else if (term)
        begin
            count_next = '0;
            if (count_reg != '0)
            begin
                produce = 1'b1;
                if (count_reg < COUNT_W'(LINE_LEN))
                begin
                    status_next = STATUS_SHORT;
                end
                else if (!format_ok)
                begin
                    status_next = STATUS_FORMAT;
                end
                else
                begin
                    node_next  = node_val;
                    digit_next = digit_val;
                    if (node_val > NODE_MAX)
                    begin
                        status_next = STATUS_RANGE;
                    end
                    else if (digit_val > DIGIT_W'(1))
                    begin
                        status_next = STATUS_STATE;
                    end
                    else if (node_val == '0)
                    begin
                        status_next = STATUS_REPORT;
                    end
                    else
                    begin
                        status_next = STATUS_SET;
                        for (int i = 0; i < MASK_W; i++)
                        begin
                            if (node_val == NODE_W'(i + 1))
                            begin
                                fence_next[i] = (digit_val == '0);
                            end
                        end
                    end
                end
            end
        end
        else if (count_reg >= COUNT_W'(LINE_LEN))
        begin
            count_next   = '0;
            discard_next = 1'b1;
            produce      = 1'b1;
            status_next  = STATUS_LONG;
        end
        else
        begin
            buf_write  = 1'b1;
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign advance  = in_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            count_reg     <= '0;
            discard_reg   <= 1'b0;
            fence_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                count_reg   <= count_next;
                discard_reg <= discard_next;
                fence_reg   <= fence_next;
            end
            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
        if (advance && buf_write)
        begin
            line_reg[count_reg[1:0]] <= char_reg;
        end
        if (advance && produce)
        begin
            status_reg <= status_next;
            node_reg   <= node_next;
            digit_reg  <= digit_next;
            mask_reg   <= fence_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {mask_reg, digit_reg, node_reg};
    assign m_tuser  = status_reg;

endmodule
